/* hdl/uuidp_pkg.sv */
// shared types, constants and character decode functions for the uuid text parser
package uuidp_pkg;

  localparam int unsigned COUNT_W        = 6;
  localparam int unsigned COMPACT_LEN    = 32;
  localparam int unsigned DASHED_LEN     = 36;
  localparam int unsigned BRACED_LEN     = 38;
  localparam int unsigned COUNT_SAT      = 39;
  localparam int unsigned DASH_POS_A     = 8;
  localparam int unsigned DASH_POS_B     = 13;
  localparam int unsigned DASH_POS_C     = 18;
  localparam int unsigned DASH_POS_D     = 23;
  localparam int unsigned HEX_ALPHA_OFFS = 10;
  localparam int unsigned NIB_BITS       = 4 * COMPACT_LEN;
  localparam int unsigned QUEUE_DEPTH    = 4;

  localparam logic [7:0] CH_DASH   = 8'h2d;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;

  // one classified character, front to back
  typedef struct packed {
    logic               has;
    logic               last;
    logic               swap;
    logic               hex;
    logic [3:0]         nib;
    logic               bad_compact;
    logic               bad_dashed;
    logic               bad_braced;
    logic [COUNT_W-1:0] count;
  } token_t;

  // bit 4 flags a hex digit, bits 3:0 its value
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] res;
    res = '0;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      res = {1'b1, 4'(c - CH_ZERO)};
    end else if (c inside {[CH_UP_A:CH_UP_F]}) begin
      res = {1'b1, 4'(c - CH_UP_A + 8'(HEX_ALPHA_OFFS))};
    end else if (c inside {[CH_LO_A:CH_LO_F]}) begin
      res = {1'b1, 4'(c - CH_LO_A + 8'(HEX_ALPHA_OFFS))};
    end
    return res;
  endfunction

  function automatic logic is_dash_pos(input logic [COUNT_W-1:0] p);
    return (p == COUNT_W'(DASH_POS_A)) || (p == COUNT_W'(DASH_POS_B)) ||
           (p == COUNT_W'(DASH_POS_C)) || (p == COUNT_W'(DASH_POS_D));
  endfunction

endpackage

/* hdl/uuidp_front.sv */
// front end: tracks the character position and classifies each word against the three forms
module uuidp_front
  import uuidp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_ready,
  input  logic [7:0]   in_char_byte,
  input  logic         in_has_char,
  input  logic         in_last_char,
  input  logic         in_swap_time_parts,
  output logic         push,
  output token_t       tok
);

  logic [COUNT_W-1:0] pos_r, pos_nxt;
  logic [COUNT_W-1:0] pos_m1;
  logic [COUNT_W-1:0] count_after;
  logic [4:0]         dec;
  logic               is_hex, is_dash;
  logic               dashed_ok_here, braced_mid_ok;

  assign push    = in_valid && in_ready;
  assign dec     = hex_decode(in_char_byte);
  assign is_hex  = dec[4];
  assign is_dash = (in_char_byte == CH_DASH);
  assign pos_m1  = pos_r - COUNT_W'(1);

  assign count_after = (in_has_char && pos_r != COUNT_W'(COUNT_SAT)) ?
                       pos_r + COUNT_W'(1) : pos_r;

  assign dashed_ok_here = is_dash_pos(pos_r) ? is_dash : is_hex;
  // braced form: the dashed layout shifted by the opening brace
  assign braced_mid_ok  = is_dash_pos(pos_m1) ? is_dash : is_hex;

  always_comb begin
    tok             = '0;
    tok.has         = in_has_char;
    tok.last        = in_last_char;
    tok.swap        = in_swap_time_parts;
    tok.hex         = is_hex;
    tok.nib         = dec[3:0];
    tok.count       = count_after;
    tok.bad_compact = (pos_r < COUNT_W'(COMPACT_LEN)) && !is_hex;
    tok.bad_dashed  = (pos_r < COUNT_W'(DASHED_LEN)) && !dashed_ok_here;
    if (pos_r == '0) begin
      tok.bad_braced = (in_char_byte != CH_LBRACE);
    end else if (pos_r < COUNT_W'(BRACED_LEN - 1)) begin
      tok.bad_braced = !braced_mid_ok;
    end else if (pos_r == COUNT_W'(BRACED_LEN - 1)) begin
      tok.bad_braced = (in_char_byte != CH_RBRACE);
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (push) begin
      pos_nxt = in_last_char ? '0 : count_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

/* hdl/uuidp_fifo.sv */
// short token queue between front and back
module uuidp_fifo
  import uuidp_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  token_t push_tok,
  output logic   not_full,
  input  logic   pop,
  output logic   not_empty,
  output token_t pop_tok
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  token_t        mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign not_full  = (count_r != CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_tok   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

/* hdl/uuidp_back.sv */
// back end: gathers nibbles and form checks, builds the result word in the output register
module uuidp_back
  import uuidp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          tok_valid,
  input  token_t        tok,
  output logic          pop,
  output logic          out_word_valid,
  input  logic          out_ready,
  output logic          out_is_valid,
  output logic [63:0]   out_uuid_high,
  output logic [63:0]   out_uuid_low
);

  logic [NIB_BITS-1:0] nib_r, nib_nxt;
  logic                ok_c_r, ok_c_nxt;
  logic                ok_d_r, ok_d_nxt;
  logic                ok_b_r, ok_b_nxt;
  logic                res_valid_r, res_valid_nxt;
  logic                res_ok_r, res_ok_nxt;
  logic [63:0]         hi_r, hi_nxt;
  logic [63:0]         lo_r, lo_nxt;
  logic                ok_c_now, ok_d_now, ok_b_now, good;
  logic [63:0]         raw_hi, raw_lo;

  // a result word only waits on the output slot
  assign pop = tok_valid && (!tok.last || !res_valid_r || out_ready);

  assign ok_c_now = ok_c_r && !(tok.has && tok.bad_compact);
  assign ok_d_now = ok_d_r && !(tok.has && tok.bad_dashed);
  assign ok_b_now = ok_b_r && !(tok.has && tok.bad_braced);
  assign nib_nxt  = (pop && tok.has && tok.hex) ? {nib_r[NIB_BITS-5:0], tok.nib} : nib_r;

  assign good = (tok.count == COUNT_W'(COMPACT_LEN) && ok_c_now) ||
                (tok.count == COUNT_W'(DASHED_LEN)  && ok_d_now) ||
                (tok.count == COUNT_W'(BRACED_LEN)  && ok_b_now);

  assign raw_hi = nib_nxt[NIB_BITS-1:64];
  assign raw_lo = nib_nxt[63:0];

  always_comb begin
    ok_c_nxt      = ok_c_r;
    ok_d_nxt      = ok_d_r;
    ok_b_nxt      = ok_b_r;
    res_valid_nxt = res_valid_r && !out_ready;
    res_ok_nxt    = res_ok_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    if (pop) begin
      if (tok.last) begin
        ok_c_nxt      = 1'b1;
        ok_d_nxt      = 1'b1;
        ok_b_nxt      = 1'b1;
        res_valid_nxt = 1'b1;
        res_ok_nxt    = good;
        if (!good) begin
          hi_nxt = '0;
        end else if (tok.swap) begin
          // time high field first, then time mid, then time low
          hi_nxt = {raw_hi[15:0], raw_hi[31:16], raw_hi[63:32]};
        end else begin
          hi_nxt = raw_hi;
        end
        lo_nxt = good ? raw_lo : '0;
      end else begin
        ok_c_nxt = ok_c_now;
        ok_d_nxt = ok_d_now;
        ok_b_nxt = ok_b_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_c_r      <= 1'b1;
      ok_d_r      <= 1'b1;
      ok_b_r      <= 1'b1;
      res_valid_r <= 1'b0;
    end else begin
      ok_c_r      <= ok_c_nxt;
      ok_d_r      <= ok_d_nxt;
      ok_b_r      <= ok_b_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nib_r    <= nib_nxt;
    res_ok_r <= res_ok_nxt;
    hi_r     <= hi_nxt;
    lo_r     <= lo_nxt;
  end

  assign out_word_valid = res_valid_r;
  assign out_is_valid   = res_ok_r;
  assign out_uuid_high  = hi_r;
  assign out_uuid_low   = lo_r;

endmodule

/* hdl/uuid_text_to_binary_parser_core.sv */
// top level of the uuid text to binary parser
// Takes one text character per word and gives one result word on the word marked last:
// a valid flag and the 16 binary bytes, zero when the text is not 32 hex digits, the
// 36-character dashed form or the braced 38-character form. A word with in_has_char low
// carries no character; with in_last_char high it closes the string as it stands. One
// word is taken every cycle while the queue has room, with no bubbles between strings;
// the result is offered once its last word has passed through the token queue and then
// the output register (classification itself is combinational). The queue (QUEUE_DEPTH
// entries) lets characters keep flowing while a finished result waits on out_ready;
// in_ready drops only when it is full.
module uuid_text_to_binary_parser_core
  import uuidp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_byte,
  input  logic        in_has_char,
  input  logic        in_last_char,
  input  logic        in_swap_time_parts,
  output logic        out_word_valid,
  input  logic        out_ready,
  output logic        out_is_valid,
  output logic [63:0] out_uuid_high,
  output logic [63:0] out_uuid_low
);

  token_t front_tok, back_tok;
  logic   push, pop, not_empty;

  uuidp_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_char_byte       (in_char_byte),
    .in_has_char        (in_has_char),
    .in_last_char       (in_last_char),
    .in_swap_time_parts (in_swap_time_parts),
    .push               (push),
    .tok                (front_tok)
  );

  uuidp_fifo #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_tok  (front_tok),
    .not_full  (in_ready),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_tok   (back_tok)
  );

  uuidp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .tok_valid      (not_empty),
    .tok            (back_tok),
    .pop            (pop),
    .out_word_valid (out_word_valid),
    .out_ready      (out_ready),
    .out_is_valid   (out_is_valid),
    .out_uuid_high  (out_uuid_high),
    .out_uuid_low   (out_uuid_low)
  );

endmodule

/* hdl/uuidp_checker.sv */
// port-level checks for the uuid parser, bound to the top level
module uuidp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_char_byte,
  input logic        in_has_char,
  input logic        in_last_char,
  input logic        in_swap_time_parts,
  input logic        out_word_valid,
  input logic        out_ready,
  input logic        out_is_valid,
  input logic [63:0] out_uuid_high,
  input logic [63:0] out_uuid_low
);

  // reset leaves no result pending
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_word_valid)
    else $error("result word shown straight after reset");

  // a rejected string never leaks decoded bytes
  a_zero_when_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_word_valid && !out_is_valid |-> (out_uuid_high == 64'd0) && (out_uuid_low == 64'd0))
    else $error("invalid result carries non-zero bytes");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_word_valid && !out_ready |=> out_word_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_word_valid && !out_ready |=> $stable(out_is_valid) && $stable(out_uuid_high) &&
                                    $stable(out_uuid_low))
    else $error("result word changed while stalled");

  // a waiting input word is held by the sender
  a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_char_byte) && $stable(in_has_char) &&
                              $stable(in_last_char) && $stable(in_swap_time_parts))
    else $error("input word changed while waiting");

endmodule

bind uuid_text_to_binary_parser_core uuidp_checker u_checker (.*);

/* sim/uuid_text_to_binary_parser_core_tb.sv */
// testbench for the uuid text parser: directed and random strings checked against a local decoder
`timescale 1ns / 1ps

module uuid_text_to_binary_parser_core_tb;
  import uuidp_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 5000;
  localparam int unsigned TEXT_WORDS  = 1500;
  localparam int unsigned MIN_STRINGS = 60;

  // characters just either side of the hex ranges, plus the framing characters
  localparam logic [7:0] NEAR_HEX [9] = '{8'h2f, 8'h3a, 8'h40, 8'h47, 8'h60, 8'h67,
                                          CH_DASH, CH_LBRACE, CH_RBRACE};

  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       last;
    logic       swap;
  } text_word_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] hi;
    logic [63:0] lo;
  } uuid_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char_byte = '0;
  logic        in_has_char = 1'b0;
  logic        in_last_char = 1'b0;
  logic        in_swap_time_parts = 1'b0;
  logic        out_word_valid;
  logic        out_ready = 1'b0;
  logic        out_is_valid;
  logic [63:0] out_uuid_high;
  logic [63:0] out_uuid_low;

  text_word_t   pending_words [$];
  uuid_result_t expected_uuids [$];
  logic [7:0]   text_buf [$];

  // local copy of the parser state
  logic [7:0]         text_store [BRACED_LEN];
  logic [COUNT_W-1:0] text_count = '0;

  int unsigned errors = 0;
  int unsigned text_words = 0;
  int unsigned strings_sent = 0;
  int unsigned results_checked = 0;
  int unsigned valid_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_cycle = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  uuid_text_to_binary_parser_core uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_char_byte       (in_char_byte),
    .in_has_char        (in_has_char),
    .in_last_char       (in_last_char),
    .in_swap_time_parts (in_swap_time_parts),
    .out_word_valid     (out_word_valid),
    .out_ready          (out_ready),
    .out_is_valid       (out_is_valid),
    .out_uuid_high      (out_uuid_high),
    .out_uuid_low       (out_uuid_low)
  );

  always #1 clk = ~clk;

  // bit 4 set for a hex digit, value in bits 3:0
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      return {1'b1, c[3:0]};
    end
    // letters a-f sit at low nibble 1-6 in both cases
    if ((c >= CH_UP_A && c <= CH_UP_F) || (c >= CH_LO_A && c <= CH_LO_F)) begin
      return {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return 5'b0;
  endfunction

  function automatic logic is_dash_slot(input int unsigned p);
    return p == DASH_POS_A || p == DASH_POS_B || p == DASH_POS_C || p == DASH_POS_D;
  endfunction

  function automatic logic decode_text(input int unsigned start, input int unsigned len,
                                       input logic dashed, output logic [127:0] packed_bytes);
    int unsigned nibs;
    int unsigned p;
    logic [4:0]  d;
    packed_bytes = '0;
    nibs = 0;
    for (p = 0; p < len; p++) begin
      if (dashed && is_dash_slot(p)) begin
        if (text_store[start + p] != CH_DASH) return 1'b0;
      end else begin
        d = nibble_of(text_store[start + p]);
        if (!d[4]) return 1'b0;
        packed_bytes = {packed_bytes[123:0], d[3:0]};
        nibs++;
      end
    end
    return nibs == COMPACT_LEN;
  endfunction

  task automatic predict_word(input text_word_t w);
    uuid_result_t r;
    logic [127:0] packed_bytes;
    logic         ok;
    if (w.has) begin
      if (text_count < BRACED_LEN) text_store[text_count] = w.ch;
      if (text_count < COUNT_SAT) text_count++;
    end
    if (w.last) begin
      ok = 1'b0;
      packed_bytes = '0;
      if (text_count == COMPACT_LEN) begin
        ok = decode_text(0, COMPACT_LEN, 1'b0, packed_bytes);
      end else if (text_count == DASHED_LEN) begin
        ok = decode_text(0, DASHED_LEN, 1'b1, packed_bytes);
      end else if (text_count == BRACED_LEN && text_store[0] == CH_LBRACE &&
                   text_store[BRACED_LEN - 1] == CH_RBRACE) begin
        ok = decode_text(1, DASHED_LEN, 1'b1, packed_bytes);
      end
      if (!ok) packed_bytes = '0;
      r.ok = ok;
      r.lo = packed_bytes[63:0];
      // swapped order puts the time high field first, then mid, then low
      r.hi = w.swap ? {packed_bytes[79:64], packed_bytes[95:80], packed_bytes[127:96]}
                    : packed_bytes[127:64];
      expected_uuids.push_back(r);
      text_count = '0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic logic [7:0] rand_hex_char();
    int unsigned v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(CH_ZERO + v);
    if ($urandom_range(0, 1) == 1) return 8'(CH_LO_A + v - 10);
    return 8'(CH_UP_A + v - 10);
  endfunction

  task automatic load_string(input string s);
    int i;
    text_buf.delete();
    for (i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  // 0 compact, 1 dashed, 2 braced
  task automatic build_uuid(input int unsigned form);
    int unsigned p;
    text_buf.delete();
    if (form == 2) text_buf.push_back(CH_LBRACE);
    for (p = 0; p < ((form == 0) ? COMPACT_LEN : DASHED_LEN); p++) begin
      if (form != 0 && is_dash_slot(p)) text_buf.push_back(CH_DASH);
      else text_buf.push_back(rand_hex_char());
    end
    if (form == 2) text_buf.push_back(CH_RBRACE);
  endtask

  task automatic mangle_text();
    int unsigned pos;
    logic [7:0]  ch;
    pos = $urandom_range(0, text_buf.size() - 1);
    ch = ($urandom_range(0, 1) == 1) ? NEAR_HEX[$urandom_range(0, 8)] : 8'($urandom());
    case ($urandom_range(0, 2))
      0: text_buf[pos] = ch;
      1: text_buf.delete(pos);
      default: text_buf.insert(pos, rand_hex_char());
    endcase
  endtask

  // noise scatters empty words through the string; bare_end closes it with an empty word
  task automatic queue_text(input logic swap, input logic noise, input logic bare_end);
    text_word_t w;
    int unsigned i;
    for (i = 0; i < text_buf.size(); i++) begin
      if (noise && $urandom_range(0, 7) == 0) begin
        w = '{ch: 8'($urandom()), has: 1'b0, last: 1'b0, swap: 1'($urandom())};
        pending_words.push_back(w);
      end
      w.ch = text_buf[i];
      w.has = 1'b1;
      w.last = !bare_end && (i == text_buf.size() - 1);
      w.swap = w.last ? swap : 1'($urandom());
      pending_words.push_back(w);
      text_words++;
    end
    if (bare_end || text_buf.size() == 0) begin
      w = '{ch: 8'($urandom()), has: 1'b0, last: 1'b1, swap: swap};
      pending_words.push_back(w);
      text_words++;
    end
    strings_sent++;
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin
    text_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_words.size() != 0) begin
        w = pending_words.pop_front();
        in_valid <= 1'b1;
        in_char_byte <= w.ch;
        in_has_char <= w.has;
        in_last_char <= w.last;
        in_swap_time_parts <= w.swap;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern steps through four modes in turn, chosen from rx_cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      case ((rx_cycle >> 8) & 3)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom());
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ((rx_cycle % 11) < 4);
      endcase
      rx_cycle++;
    end
  end

  // monitor, scoreboard and watchdog
  always @(posedge clk) begin
    text_word_t   seen;
    uuid_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        seen.ch = in_char_byte;
        seen.has = in_has_char;
        seen.last = in_last_char;
        seen.swap = in_swap_time_parts;
        predict_word(seen);
      end
      if (out_word_valid && out_ready) begin
        if (expected_uuids.size() == 0) begin
          report_mismatch("unexpected result word", out_uuid_high, '0);
        end else begin
          want = expected_uuids.pop_front();
          if (out_is_valid !== want.ok) report_mismatch("is_valid", 64'(out_is_valid),
                                                        64'(want.ok));
          if (out_uuid_high !== want.hi) report_mismatch("uuid_high", out_uuid_high, want.hi);
          if (out_uuid_low !== want.lo) report_mismatch("uuid_low", out_uuid_low, want.lo);
          results_checked++;
          if (want.ok) valid_seen++;
        end
      end
      if ((in_valid && in_ready) || (out_word_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
        $display("uuid_text_to_binary_parser_core_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    int unsigned pick;
    int unsigned n;
    // directed strings
    text_buf.delete();
    queue_text(1'b0, 1'b0, 1'b0);
    load_string("0123456789abcdefABCDEF0123456789");
    queue_text(1'b0, 1'b0, 1'b0);
    load_string("ffffffff-ffff-ffff-ffff-ffffffffffff");
    queue_text(1'b1, 1'b0, 1'b0);
    load_string("{00112233-4455-6677-8899-AABBCCDDEEFF}");
    queue_text(1'b1, 1'b0, 1'b0);
    queue_text(1'b0, 1'b0, 1'b0);
    load_string("{00112233-4455-6677-8899-AABBCCDDEEFF)");
    queue_text(1'b0, 1'b0, 1'b0);
    load_string("00112233-4455-6677-8899-aabbccddeeff00");
    queue_text(1'b0, 1'b0, 1'b0);
    load_string("{00112233-4455-6677-8899-AABBCCDDEEFF}0");
    queue_text(1'b0, 1'b0, 1'b0);
    load_string("{00112233-4455-6677-8899-AABBCCDDEEFF}0123456");
    queue_text(1'b1, 1'b0, 1'b0);
    load_string("0123456789abcdefABCDEF012345678g");
    queue_text(1'b0, 1'b0, 1'b0);
    load_string("00112233-4455x6677-8899-aabbccddeeff");
    queue_text(1'b0, 1'b0, 1'b0);
    load_string("0123456789abcdefABCDEF012345678");
    queue_text(1'b0, 1'b0, 1'b0);
    load_string("0123456789abcdefABCDEF0123456789");
    queue_text(1'b1, 1'b1, 1'b1);

    // random strings, mostly well formed
    while (text_words < TEXT_WORDS || strings_sent < MIN_STRINGS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        build_uuid($urandom_range(0, 2));
      end else if (pick < 80) begin
        build_uuid($urandom_range(0, 2));
        n = $urandom_range(1, 2);
        repeat (n) mangle_text();
      end else if (pick < 88) begin
        build_uuid(2);
        n = $urandom_range(1, 12);
        repeat (n) text_buf.push_back(rand_hex_char());
      end else begin
        text_buf.delete();
        n = $urandom_range(0, 45);
        repeat (n) text_buf.push_back(8'($urandom()));
      end
      queue_text(1'($urandom()), $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_valid || expected_uuids.size() != 0) begin
      @(negedge clk);
    end
    repeat (12) @(posedge clk);

    $display("sent %0d strings in %0d text words (empty, compact, dashed, braced, broken)",
             strings_sent, text_words);
    $display("checked %0d results, %0d of them well formed", results_checked, valid_seen);
    if (errors == 0) begin
      $display("uuid_text_to_binary_parser_core_tb: clean");
    end else begin
      $display("uuid_text_to_binary_parser_core_tb: errors");
    end
    $finish;
  end

endmodule
